FILE: rtl/core/sdld_pkg.sv
// Shared types and constants for the signed decimal long divider.
// Used by sdld_ctrl, sdld_dp and the signed_decimal_long_division top level.
package sdld_pkg;

    localparam int DATA_W             = 32;
    localparam int FRAC_W             = 30;
    localparam int DIGITS_W           = 4;
    localparam int DEFAULT_MAX_FRAC_DIGITS = 9;
    // remainder times ten stays below 10 * 2^31
    localparam int REM_W              = 36;
    localparam int BIT_CNT_W          = $clog2(DATA_W);
    localparam int DIG_BIT_W          = 2;

    typedef struct packed {
        logic                 load;
        logic                 int_step;
        logic                 ten_step;
        logic                 dig_step;
        logic [DIG_BIT_W-1:0] dig_bit;
        logic                 out_load;
    } sdld_cmd_t;

    typedef struct packed {
        logic div_zero;
    } sdld_sts_t;

endpackage

FILE: rtl/core/sdld_ctrl.sv
// Sequencer for the signed decimal long divider: integer bits, then digits.
// Depends on sdld_pkg; drives sdld_dp through sdld_cmd_t.
module sdld_ctrl import sdld_pkg::*; #(
    parameter int MAX_FRAC_DIGITS = DEFAULT_MAX_FRAC_DIGITS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [DIGITS_W-1:0] s_frac_digits,
    output logic                m_valid,
    input  logic                m_ready,
    input  sdld_sts_t           sts,
    output sdld_cmd_t           cmd
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_INT  = 5'b00010,
        ST_TEN  = 5'b00100,
        ST_DIG  = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    localparam logic [DIGITS_W-1:0] MaxDigits = DIGITS_W'(MAX_FRAC_DIGITS);

    state_t                state_reg, state_next;
    logic [BIT_CNT_W-1:0]  bit_cnt_reg, bit_cnt_next;
    logic [DIG_BIT_W-1:0]  dig_bit_reg, dig_bit_next;
    logic [DIGITS_W-1:0]   digits_reg, digits_next;
    logic                  m_valid_reg, m_valid_next;
    logic                  accept;
    logic                  out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        bit_cnt_next = bit_cnt_reg;
        dig_bit_next = dig_bit_reg;
        digits_next  = digits_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        cmd.dig_bit  = dig_bit_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.load     = 1'b1;
                    bit_cnt_next = BIT_CNT_W'(DATA_W - 1);
                    digits_next  = (s_frac_digits > MaxDigits) ? MaxDigits : s_frac_digits;
                    state_next   = ST_INT;
                end
            end
            ST_INT: begin
                if (sts.div_zero) begin
                    state_next = ST_DONE;
                end else begin
                    cmd.int_step = 1'b1;
                    bit_cnt_next = bit_cnt_reg - 1'b1;
                    if (bit_cnt_reg == '0) begin
                        state_next = (digits_reg == '0) ? ST_DONE : ST_TEN;
                    end
                end
            end
            ST_TEN: begin
                cmd.ten_step = 1'b1;
                dig_bit_next = '1;
                state_next   = ST_DIG;
            end
            ST_DIG: begin
                cmd.dig_step = 1'b1;
                dig_bit_next = dig_bit_reg - 1'b1;
                if (dig_bit_reg == '0) begin
                    digits_next = digits_reg - 1'b1;
                    state_next  = (digits_reg == DIGITS_W'(1)) ? ST_DONE : ST_TEN;
                end
            end
            ST_DONE: begin
                // hold the finished result until the output register frees up
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            bit_cnt_reg <= '0;
            dig_bit_reg <= '0;
            digits_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            bit_cnt_reg <= bit_cnt_next;
            dig_bit_reg <= dig_bit_next;
            digits_reg  <= digits_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

FILE: rtl/core/sdld_dp.sv
// Datapath of the signed decimal long divider: magnitudes, restoring
// subtractor, times-ten step and the output register. Depends on sdld_pkg.
module sdld_dp import sdld_pkg::*; (
    input  logic                     aclk,
    input  logic signed [DATA_W-1:0] s_dividend,
    input  logic signed [DATA_W-1:0] s_divisor_in,
    input  sdld_cmd_t                cmd,
    output sdld_sts_t                sts,
    output logic                     m_negative,
    output logic [DATA_W-1:0]        m_int_part,
    output logic [FRAC_W-1:0]        m_frac_part,
    output logic                     m_div_by_zero
);

    logic [DATA_W-1:0] quo_reg, quo_next;
    logic [DATA_W-1:0] mb_reg, mb_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [FRAC_W-1:0] frac_reg, frac_next;
    logic              neg_reg, neg_next;
    logic              dz_reg, dz_next;

    logic              out_neg_reg;
    logic [DATA_W-1:0] out_int_reg;
    logic [FRAC_W-1:0] out_frac_reg;
    logic              out_dz_reg;

    logic [DATA_W:0]   trial;
    logic [DATA_W:0]   int_diff;
    logic [REM_W-1:0]  div_sh;
    logic [REM_W-1:0]  dig_diff;
    logic              dig_fits;

    assign sts.div_zero  = dz_reg;
    assign m_negative    = out_neg_reg;
    assign m_int_part    = out_int_reg;
    assign m_frac_part   = out_frac_reg;
    assign m_div_by_zero = out_dz_reg;

    // one quotient bit per integer step
    assign trial    = {rem_reg[DATA_W-1:0], quo_reg[DATA_W-1]};
    assign int_diff = trial - {1'b0, mb_reg};

    // one binary digit bit per digit step: compare against divisor << bit
    assign div_sh   = REM_W'(mb_reg) << cmd.dig_bit;
    assign dig_fits = (rem_reg >= div_sh);
    assign dig_diff = rem_reg - div_sh;

    always_comb begin
        quo_next  = quo_reg;
        mb_next   = mb_reg;
        rem_next  = rem_reg;
        frac_next = frac_reg;
        neg_next  = neg_reg;
        dz_next   = dz_reg;

        if (cmd.load) begin
            quo_next  = s_dividend[DATA_W-1] ? (~s_dividend + DATA_W'(1)) : s_dividend;
            mb_next   = s_divisor_in[DATA_W-1] ? (~s_divisor_in + DATA_W'(1)) : s_divisor_in;
            rem_next  = '0;
            frac_next = '0;
            neg_next  = s_dividend[DATA_W-1] ^ s_divisor_in[DATA_W-1];
            dz_next   = (s_divisor_in == '0);
        end else if (cmd.int_step) begin
            if (trial >= {1'b0, mb_reg}) begin
                rem_next = REM_W'(int_diff);
                quo_next = {quo_reg[DATA_W-2:0], 1'b1};
            end else begin
                rem_next = REM_W'(trial);
                quo_next = {quo_reg[DATA_W-2:0], 1'b0};
            end
        end else if (cmd.ten_step) begin
            rem_next  = (rem_reg << 3) + (rem_reg << 1);
            frac_next = (frac_reg << 3) + (frac_reg << 1);
        end else if (cmd.dig_step) begin
            if (dig_fits) begin
                rem_next  = dig_diff;
                frac_next = frac_reg + (FRAC_W'(1) << cmd.dig_bit);
            end
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg  <= quo_next;
        mb_reg   <= mb_next;
        rem_reg  <= rem_next;
        frac_reg <= frac_next;
        neg_reg  <= neg_next;
        dz_reg   <= dz_next;
        if (cmd.out_load) begin
            // drop the result fields on a zero divisor
            out_neg_reg  <= neg_reg && !dz_reg;
            out_int_reg  <= dz_reg ? '0 : quo_reg;
            out_frac_reg <= dz_reg ? '0 : frac_reg;
            out_dz_reg   <= dz_reg;
        end
    end

endmodule

FILE: rtl/core/signed_decimal_long_division.sv
// Signed decimal long divider. One item is worked at a time: after the beat
// is taken, the magnitudes go through a one-bit restoring subtractor for all
// 32 integer bits, then each fraction digit takes one times-ten step and four
// subtract steps, d being frac_digits saturated to MAX_FRAC_DIGITS (nine by
// default); a zero divisor skips the steps and goes straight to the result.
// The finished result sits in an output register, and the next input beat is
// taken while it waits.
// The value is (-1)^negative * (int_part + frac_part / 10^d), truncated.
module signed_decimal_long_division import sdld_pkg::*; #(
    parameter int MAX_FRAC_DIGITS = DEFAULT_MAX_FRAC_DIGITS
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [DATA_W-1:0] s_dividend,
    input  logic signed [DATA_W-1:0] s_divisor_in,
    input  logic [DIGITS_W-1:0]      s_frac_digits,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic                     m_negative,
    output logic [DATA_W-1:0]        m_int_part,
    output logic [FRAC_W-1:0]        m_frac_part,
    output logic                     m_div_by_zero
);

    sdld_cmd_t cmd;
    sdld_sts_t sts;

    sdld_ctrl #(
        .MAX_FRAC_DIGITS(MAX_FRAC_DIGITS)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_frac_digits (s_frac_digits),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .sts           (sts),
        .cmd           (cmd)
    );

    sdld_dp u_dp (
        .aclk          (aclk),
        .s_dividend    (s_dividend),
        .s_divisor_in  (s_divisor_in),
        .cmd           (cmd),
        .sts           (sts),
        .m_negative    (m_negative),
        .m_int_part    (m_int_part),
        .m_frac_part   (m_frac_part),
        .m_div_by_zero (m_div_by_zero)
    );

endmodule

FILE: rtl/core/sdld_checker.sv
// Port-level checks for signed_decimal_long_division, bound to the top level.
// Depends on sdld_pkg.
module sdld_checker import sdld_pkg::*; (
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     s_valid,
    input logic                     s_ready,
    input logic signed [DATA_W-1:0] s_dividend,
    input logic signed [DATA_W-1:0] s_divisor_in,
    input logic [DIGITS_W-1:0]      s_frac_digits,
    input logic                     m_valid,
    input logic                     m_ready,
    input logic                     m_negative,
    input logic [DATA_W-1:0]        m_int_part,
    input logic [FRAC_W-1:0]        m_frac_part,
    input logic                     m_div_by_zero
);

    localparam logic [FRAC_W-1:0] MaxFrac = FRAC_W'(999999999);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_int_part) && $stable(m_frac_part)
            && $stable(m_negative) && $stable(m_div_by_zero))
        else $error("result beat changed while stalled");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("block not idle after reset");

    // one item at a time: busy right after an input beat
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while an item is in flight");

    a_zero_div_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_div_by_zero |-> m_int_part == '0 && m_frac_part == '0 && !m_negative)
        else $error("nonzero fields on a zero divisor");

    a_frac_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_frac_part <= MaxFrac)
        else $error("fraction exceeds nine digits");

endmodule

bind signed_decimal_long_division sdld_checker u_sdld_checker (.*);
